// ===== rtl/png_chunk_crc_checker_defines.svh =====
// Assertion macros shared by the PNG chunk CRC checker RTL.
`ifndef PNG_CHUNK_CRC_CHECKER_DEFINES_SVH
`define PNG_CHUNK_CRC_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define PCC_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCC_ASSERT_HOLDS(label, clk, rst, ante, cons, msg)
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/pcc_pkg.sv =====
// Types, constants and the CRC-32 byte update for the PNG chunk CRC checker.
package pcc_pkg;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_IDLE = 3'd5
  } phase_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_BAD_SIG  = 2'd2;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;

  localparam logic [7:0] PNG_SIG [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
    logic        end_chunk;
  } result_t;

  // Reflected CRC-32 over one byte, eight shift steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/pcc_parser.sv =====
// Chunk framing state machine, CRC update and result register.
`include "png_chunk_crc_checker_defines.svh"

module pcc_parser
  import pcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_beat_t in_beat,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_result
);

  phase_t      phase, phase_next;
  logic [2:0]  byte_index, byte_index_next;
  logic        signature_bad, signature_bad_next;
  logic [31:0] length_reg, length_reg_next;
  logic [31:0] type_reg, type_reg_next;
  logic [31:0] remaining_count, remaining_count_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] trailer_crc, trailer_crc_next;

  phase_t      cur_phase;
  logic [2:0]  cur_index;
  logic        cur_bad;
  logic        sig_bad_now;
  logic        field_done;
  logic        consume;
  logic        emit;
  result_t     result;
  logic [31:0] crc_upd;
  logic [31:0] trailer_shift;
  logic [31:0] crc_final;
  logic [31:0] remaining_dec;
  logic [7:0]  b;

  // The result register frees up when it is empty or is being taken.
  assign in_ready = !out_valid || out_ready;
  assign consume  = in_valid && in_ready;
  assign b        = in_beat.data_byte;

  // A start-of-file beat restarts the signature check on this very byte.
  always_comb begin
    cur_phase = in_beat.start_of_file ? PH_SIG : phase;
    cur_index = in_beat.start_of_file ? 3'd0 : byte_index;
    cur_bad   = in_beat.start_of_file ? 1'b0 : signature_bad;
  end

  assign sig_bad_now   = cur_bad || (b != PNG_SIG[cur_index]);
  assign field_done    = (cur_index >= 3'd3);
  assign crc_upd       = crc_byte(running_crc, b);
  assign trailer_shift = {trailer_crc[23:0], b};
  assign crc_final     = running_crc ^ CRC_ONES;
  assign remaining_dec = remaining_count - 32'd1;

  always_comb begin
    phase_next = cur_phase;
    case (cur_phase)
      PH_SIG: begin
        if (cur_index == 3'd7) begin
          phase_next = sig_bad_now ? PH_IDLE : PH_LEN;
        end
      end
      PH_LEN: begin
        if (field_done) begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (field_done) begin
          phase_next = (length_reg == 32'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        if (remaining_dec == 32'd0) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        if (field_done) begin
          phase_next = (type_reg == TYPE_IEND) ? PH_IDLE : PH_LEN;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    byte_index_next      = cur_index;
    signature_bad_next   = cur_bad;
    length_reg_next      = length_reg;
    type_reg_next        = type_reg;
    remaining_count_next = remaining_count;
    running_crc_next     = running_crc;
    trailer_crc_next     = trailer_crc;
    emit                 = 1'b0;
    result               = '0;
    case (cur_phase)
      PH_SIG: begin
        signature_bad_next = sig_bad_now;
        if (cur_index == 3'd7) begin
          byte_index_next = 3'd0;
          if (sig_bad_now) begin
            emit          = 1'b1;
            result.status = ST_BAD_SIG;
          end
        end else begin
          byte_index_next = cur_index + 3'd1;
        end
      end
      PH_LEN: begin
        length_reg_next = {length_reg[23:0], b};
        if (field_done) begin
          byte_index_next  = 3'd0;
          running_crc_next = CRC_ONES;
        end else begin
          byte_index_next = cur_index + 3'd1;
        end
      end
      PH_TYPE: begin
        type_reg_next    = {type_reg[23:0], b};
        running_crc_next = crc_upd;
        if (field_done) begin
          byte_index_next      = 3'd0;
          remaining_count_next = length_reg;
        end else begin
          byte_index_next = cur_index + 3'd1;
        end
      end
      PH_DATA: begin
        running_crc_next     = crc_upd;
        remaining_count_next = remaining_dec;
      end
      PH_CRC: begin
        trailer_crc_next = trailer_shift;
        if (field_done) begin
          byte_index_next     = 3'd0;
          emit                = 1'b1;
          result.status       = (crc_final == trailer_shift) ? ST_OK : ST_MISMATCH;
          result.chunk_type   = type_reg;
          result.chunk_length = length_reg;
          result.computed_crc = crc_final;
          result.stored_crc   = trailer_shift;
          result.end_chunk    = (type_reg == TYPE_IEND);
        end else begin
          byte_index_next = cur_index + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIG;
      byte_index    <= 3'd0;
      signature_bad <= 1'b0;
      running_crc   <= CRC_ONES;
      out_valid     <= 1'b0;
    end else begin
      if (consume) begin
        phase         <= phase_next;
        byte_index    <= byte_index_next;
        signature_bad <= signature_bad_next;
        running_crc   <= running_crc_next;
      end
      if (consume && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg      <= 32'd0;
      type_reg        <= 32'd0;
      remaining_count <= 32'd0;
      trailer_crc     <= 32'd0;
    end else if (consume) begin
      length_reg      <= length_reg_next;
      type_reg        <= type_reg_next;
      remaining_count <= remaining_count_next;
      trailer_crc     <= trailer_crc_next;
    end
    if (consume && emit) begin
      out_result <= result;
    end
  end

  `PCC_ASSERT_HOLDS(a_bad_sig_zero, clk, rst,
    out_valid && (out_result.status == ST_BAD_SIG),
    (out_result.chunk_type == 32'd0) && (out_result.stored_crc == 32'd0) &&
    (out_result.computed_crc == 32'd0) && !out_result.end_chunk,
    "bad-signature result carries nonzero chunk fields")
  `PCC_ASSERT_HOLDS(a_ok_means_match, clk, rst,
    out_valid && (out_result.status == ST_OK),
    out_result.computed_crc == out_result.stored_crc,
    "ok status with differing CRC values")
  `PCC_ASSERT_NEXT(a_iend_goes_idle, clk, rst,
    consume && emit && result.end_chunk,
    phase == PH_IDLE,
    "parser did not stop after the IEND chunk")
  `PCC_ASSERT_HOLDS(a_index_range, clk, rst,
    phase != PH_SIG,
    byte_index <= 3'd3,
    "byte index beyond a four-byte field")
  `PCC_ASSERT_HOLDS(a_data_count_live, clk, rst,
    phase == PH_DATA,
    remaining_count != 32'd0,
    "data phase entered with no bytes left")

endmodule

// ===== rtl/png_chunk_crc_checker.sv =====
// Top level of the PNG chunk CRC checker: input register and parser.
//
//   Channel  Direction  tdata (low bit up)                         Side fields
//   s_       in         data_byte[7:0]                             tuser: start_of_file
//   m_       out        chunk_type, chunk_length, computed_crc,    tuser: status[1:0]
//                       stored_crc (32 bits each)                  tlast: end_chunk
//
// One byte is taken per cycle while s_tready is high; the CRC update of a whole byte
// is one unrolled XOR network between the input register and the running CRC register.
// A result is registered and offered on m_tvalid once the parser consumes its last beat.
// Reset puts the parser in the signature phase and empties both registers.
// While m_tready is low a pending result holds, and s_tready falls once the
// input register also holds a beat.
module png_chunk_crc_checker
  import pcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // start_of_file
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // chunk_type, chunk_length, computed_crc, stored_crc
  output logic [1:0]   m_tuser,   // status
  output logic         m_tlast    // end_chunk
);

  logic     in_valid;
  in_beat_t in_beat;
  logic     parser_ready;
  result_t  res;

  assign s_tready = !in_valid || parser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_beat.data_byte     <= s_tdata;
      in_beat.start_of_file <= s_tuser;
    end
  end

  pcc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_beat    (in_beat),
    .in_ready   (parser_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res)
  );

  assign m_tdata = {res.stored_crc, res.computed_crc, res.chunk_length, res.chunk_type};
  assign m_tuser = res.status;
  assign m_tlast = res.end_chunk;

endmodule
